@@ hdl/assert_macros.svh @@
// Assertion macros shared by the point-in-triangle search RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PITS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PITS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pits_pkg.sv @@
// Package for the point-in-triangle table search: constants, codes and the
// control structs passed between the sequencer and the cross product unit.
// No dependencies.
package pits_pkg;

    localparam int TRIANGLE_SLOTS_DEF = 256;
    localparam int COORD_WIDTH_DEF    = 16;
    localparam int INDEX_WIDTH        = 8;
    localparam int COUNT_WIDTH        = 9;
    localparam int STEP_WIDTH         = 4;

    // Eight products per triangle, plus a final step that retires the last one.
    localparam logic [STEP_WIDTH-1:0] STEP_LAST = 4'd8;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                  load_diff;
        logic                  step_en;
        logic [STEP_WIDTH-1:0] step;
    } t_cross_ctrl;

    typedef struct packed {
        logic match;
    } t_cross_stat;

endpackage

@@ hdl/pits_if.sv @@
// Handshake interfaces of the point-in-triangle table search: command,
// result and configuration channels. Depends on pits_pkg.
interface pits_cmd_if #(
    parameter int COORD_WIDTH = pits_pkg::COORD_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [pits_pkg::INDEX_WIDTH-1:0]    entry_index;
    logic signed [COORD_WIDTH-1:0]       vertex0_x;
    logic signed [COORD_WIDTH-1:0]       vertex0_z;
    logic signed [COORD_WIDTH-1:0]       vertex1_x;
    logic signed [COORD_WIDTH-1:0]       vertex1_z;
    logic signed [COORD_WIDTH-1:0]       vertex2_x;
    logic signed [COORD_WIDTH-1:0]       vertex2_z;
    logic signed [COORD_WIDTH-1:0]       query_x;
    logic signed [COORD_WIDTH-1:0]       query_z;

    modport source (
        output valid, command, entry_index, vertex0_x, vertex0_z, vertex1_x,
               vertex1_z, vertex2_x, vertex2_z, query_x, query_z,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, vertex0_x, vertex0_z, vertex1_x,
               vertex1_z, vertex2_x, vertex2_z, query_x, query_z,
        output ready
    );
endinterface

interface pits_res_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [pits_pkg::INDEX_WIDTH-1:0] triangle_index;

    modport source (output valid, found, triangle_index, input ready);
    modport sink (input valid, found, triangle_index, output ready);
endinterface

interface pits_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pits_pkg::COUNT_WIDTH-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ hdl/pits_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pits_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pits_cross_unit.sv @@
// Shared cross product unit: edge differences, one multiplier used for the
// eight products of a triangle, and the sign test. Depends on pits_pkg.
module pits_cross_unit #(
    parameter int COORD_WIDTH = pits_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic [2*COORD_WIDTH-1:0]      i_first,
    input  logic [2*COORD_WIDTH-1:0]      i_second,
    input  logic [2*COORD_WIDTH-1:0]      i_opposite,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_pz,
    input  pits_pkg::t_cross_ctrl         i_ctrl,
    output pits_pkg::t_cross_stat         o_stat
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    // Flag slot of each cross product.
    localparam int XP_AREA = 0;
    localparam int XP_S    = 1;
    localparam int XP_U    = 3;

    logic signed [CW-1:0] x0, z0, x1, z1, x2, z2;
    logic signed [DW-1:0] r_e1x, r_e1z, r_e2x, r_e2z, r_dx, r_dz;
    logic signed [DW-1:0] r_fx, r_fz, r_gx, r_gz;
    logic signed [DW-1:0] op_a, op_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] r_prod, r_first;
    logic signed [PW:0]   pair_diff;
    logic [pits_pkg::STEP_WIDTH-1:0] retire;
    logic [3:0] r_pos, r_neg;

    assign x0 = $signed(i_first[CW-1:0]);
    assign z0 = $signed(i_first[2*CW-1:CW]);
    assign x1 = $signed(i_second[CW-1:0]);
    assign z1 = $signed(i_second[2*CW-1:CW]);
    assign x2 = $signed(i_opposite[CW-1:0]);
    assign z2 = $signed(i_opposite[2*CW-1:CW]);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_diff) begin
            r_e1x <= DW'(x1) - DW'(x0);
            r_e1z <= DW'(z1) - DW'(z0);
            r_e2x <= DW'(x2) - DW'(x0);
            r_e2z <= DW'(z2) - DW'(z0);
            r_dx  <= DW'(i_px) - DW'(x0);
            r_dz  <= DW'(i_pz) - DW'(z0);
            r_fx  <= DW'(x2) - DW'(x1);
            r_fz  <= DW'(z2) - DW'(z1);
            r_gx  <= DW'(i_px) - DW'(x1);
            r_gz  <= DW'(i_pz) - DW'(z1);
        end
    end

    // Products in pairs: area, s, t and u, each as left term then right term.
    always_comb begin
        case (i_ctrl.step[2:0])
            3'd0: begin op_a = r_e1x; op_b = r_e2z; end
            3'd1: begin op_a = r_e1z; op_b = r_e2x; end
            3'd2: begin op_a = r_e2z; op_b = r_dx;  end
            3'd3: begin op_a = r_e2x; op_b = r_dz;  end
            3'd4: begin op_a = r_e1x; op_b = r_dz;  end
            3'd5: begin op_a = r_e1z; op_b = r_dx;  end
            3'd6: begin op_a = r_fx;  op_b = r_gz;  end
            default: begin op_a = r_fz; op_b = r_gx; end
        endcase
    end

    assign prod      = PW'(op_a) * PW'(op_b);
    assign pair_diff = (PW + 1)'(r_first) - (PW + 1)'(r_prod);
    assign retire    = i_ctrl.step - 1'b1;

    // Each step but the last registers a new product; each step but the first retires the one from the step before.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step_en) begin
            if (i_ctrl.step != pits_pkg::STEP_LAST) begin
                r_prod <= prod;
            end
            if (i_ctrl.step != '0) begin
                if (!retire[0]) begin
                    r_first <= r_prod;
                end else begin
                    r_pos[retire[2:1]] <= (pair_diff != '0) && !pair_diff[PW];
                    r_neg[retire[2:1]] <= pair_diff[PW];
                end
            end
        end
    end

    assign o_stat.match = r_neg[XP_AREA] ? (&r_neg[XP_U:XP_S]) : (&r_pos[XP_U:XP_S]);

endmodule

@@ hdl/point_in_triangle_table_search_unit.sv @@
// Top level of the point-in-triangle table search: sequencer, vertex stores,
// output register and assertions. Depends on pits_pkg, pits_if, pits_ram,
// pits_cross_unit and assert_macros.svh.
//
// The block holds a table of triangles given by three (x,z) vertices in
// signed fixed point. A load transaction (command 0) writes one slot as it is
// accepted; a slot at or above TRIANGLE_SLOTS is ignored. A query
// transaction (command 1) scans slots 0 to triangle_count-1 in order, capped
// at TRIANGLE_SLOTS, and returns one result with the first triangle that
// strictly contains the point; points on an edge and zero-area triangles never
// match. Every triangle passes through one shared multiplier that forms the
// eight products of the four cross products one per cycle; each scanned slot
// takes a difference load, nine multiply and retire steps and a decision, and
// i_cmd.ready stays low until the query is done. The result sits in an output
// register, so a new transaction is taken while it waits; a query that ends
// while the previous result is still unread holds until that result is taken.
// triangle_count is written through i_cfg, which is ready whenever reset is
// released, and is to be changed only while no query is in progress. Neither
// input channel is ready while reset is asserted. Slots never loaded read back
// undefined contents.
`include "assert_macros.svh"

module point_in_triangle_table_search_unit #(
    parameter int TRIANGLE_SLOTS = pits_pkg::TRIANGLE_SLOTS_DEF,
    parameter int COORD_WIDTH    = pits_pkg::COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pits_cmd_if.sink   i_cmd,
    pits_res_if.source o_res,
    pits_cfg_if.sink   i_cfg
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = (TRIANGLE_SLOTS > 1) ? $clog2(TRIANGLE_SLOTS) : 1;
    localparam int SLW = $clog2(TRIANGLE_SLOTS + 1);
    localparam int LW  = (SLW > pits_pkg::COUNT_WIDTH) ? SLW : pits_pkg::COUNT_WIDTH;
    localparam int IW  = pits_pkg::INDEX_WIDTH;
    localparam int XW  = (AW > IW) ? AW : IW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIFF = 5'b00010,
        S_MUL  = 5'b00100,
        S_EVAL = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_limit, n_limit;
    logic [pits_pkg::STEP_WIDTH-1:0] r_step, n_step;
    logic r_found, n_found;
    logic r_out_valid, n_out_valid;
    logic r_out_found;
    logic [IW-1:0] r_out_index;
    logic signed [CW-1:0] r_px, r_pz;
    logic [pits_pkg::COUNT_WIDTH-1:0] r_count;

    logic cmd_acc, is_load, is_query, slot_ok, out_free;
    logic [XW-1:0] wide_idx;
    logic [LW-1:0] pos_nxt, cap_limit;
    logic rd_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [2*CW-1:0] first_q, second_q, opposite_q;
    pits_pkg::t_cross_ctrl cross_ctrl;
    pits_pkg::t_cross_stat cross_stat;

    assign i_cmd.ready = i_rst_n && (r_state == S_IDLE);
    assign i_cfg.ready = i_rst_n;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign is_load     = cmd_acc && (i_cmd.command == pits_pkg::CMD_LOAD);
    assign is_query    = cmd_acc && (i_cmd.command == pits_pkg::CMD_QUERY);
    assign wide_idx    = XW'(i_cmd.entry_index);
    assign slot_ok     = (32'(i_cmd.entry_index) < 32'(TRIANGLE_SLOTS));
    assign wr_addr     = wide_idx[AW-1:0];
    assign pos_nxt     = r_pos + 1'b1;
    assign out_free    = !r_out_valid || o_res.ready;
    assign cap_limit   = (32'(r_count) > 32'(TRIANGLE_SLOTS)) ? LW'(TRIANGLE_SLOTS)
                                                              : LW'(r_count);

    // The stores share one write and one read address; x sits in the low half.
    pits_ram #(.WIDTH(2 * CW), .DEPTH(TRIANGLE_SLOTS)) u_first_store (
        .i_clk   (i_clk),
        .i_we    (is_load && slot_ok),
        .i_waddr (wr_addr),
        .i_wdata ({i_cmd.vertex0_z, i_cmd.vertex0_x}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (first_q)
    );

    pits_ram #(.WIDTH(2 * CW), .DEPTH(TRIANGLE_SLOTS)) u_second_store (
        .i_clk   (i_clk),
        .i_we    (is_load && slot_ok),
        .i_waddr (wr_addr),
        .i_wdata ({i_cmd.vertex1_z, i_cmd.vertex1_x}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (second_q)
    );

    pits_ram #(.WIDTH(2 * CW), .DEPTH(TRIANGLE_SLOTS)) u_opposite_store (
        .i_clk   (i_clk),
        .i_we    (is_load && slot_ok),
        .i_waddr (wr_addr),
        .i_wdata ({i_cmd.vertex2_z, i_cmd.vertex2_x}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (opposite_q)
    );

    assign cross_ctrl.load_diff = (r_state == S_DIFF);
    assign cross_ctrl.step_en   = (r_state == S_MUL);
    assign cross_ctrl.step      = r_step;

    pits_cross_unit #(.COORD_WIDTH(CW)) u_cross (
        .i_clk      (i_clk),
        .i_first    (first_q),
        .i_second   (second_q),
        .i_opposite (opposite_q),
        .i_px       (r_px),
        .i_pz       (r_pz),
        .i_ctrl     (cross_ctrl),
        .o_stat     (cross_stat)
    );

    // Sequencer. A read issued in one state delivers the entry in the next,
    // which is always the difference load.
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_limit     = r_limit;
        n_step      = r_step;
        n_found     = r_found;
        n_out_valid = r_out_valid && !o_res.ready;
        rd_en       = 1'b0;
        rd_addr     = '0;
        case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    n_pos   = '0;
                    n_limit = cap_limit;
                    n_found = 1'b0;
                    if (cap_limit == '0) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                n_step  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (r_step == pits_pkg::STEP_LAST) begin
                    n_state = S_EVAL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EVAL: begin
                if (cross_stat.match) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (pos_nxt < r_limit) begin
                    n_pos   = pos_nxt;
                    rd_en   = 1'b1;
                    rd_addr = pos_nxt[AW-1:0];
                    n_state = S_DIFF;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_limit     <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_limit     <= n_limit;
            r_step      <= n_step;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_count <= i_cfg.data;
            end
        end
    end

    // Payload registers: query point and the result word.
    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_px <= i_cmd.query_x;
            r_pz <= i_cmd.query_z;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_found <= r_found;
            r_out_index <= r_found ? r_pos[IW-1:0] : '0;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.found          = r_out_found;
    assign o_res.triangle_index = r_out_index;

    // The scan never walks past the captured limit.
    `PITS_ASSERT_NOW(a_pos_in_range, i_clk, i_rst_n,
        (r_state == S_DIFF || r_state == S_MUL || r_state == S_EVAL), (r_pos < r_limit),
        "scan position beyond the scan limit")

    // The multiply sequence stops at its last step.
    `PITS_ASSERT_NOW(a_step_bound, i_clk, i_rst_n,
        (r_state == S_MUL), (r_step <= pits_pkg::STEP_LAST), "multiply step out of range")

    // A finished query always lands in the output register.
    `PITS_ASSERT_NEXT(a_done_delivers, i_clk, i_rst_n,
        (r_state == S_DONE && out_free), (o_res.valid && r_state == S_IDLE),
        "finished query did not reach the output register")

    // A miss always reports slot zero.
    `PITS_ASSERT_NOW(a_miss_index, i_clk, i_rst_n,
        (o_res.valid && !o_res.found), (o_res.triangle_index == '0),
        "miss reported with a nonzero index")

endmodule

@@ tb/sv/point_in_triangle_table_search_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the point-in-triangle table search unit.
// Depends on pits_pkg, the pits_if interfaces and the unit's RTL; needs no files.
module point_in_triangle_table_search_unit_test;

    localparam int     TABLE_SLOTS = pits_pkg::TRIANGLE_SLOTS_DEF;
    localparam int     IDX_W       = pits_pkg::INDEX_WIDTH;
    localparam int     CNT_W       = pits_pkg::COUNT_WIDTH;
    localparam longint COORD_MAX   = 32767;
    localparam longint COORD_MIN   = -32768;
    // Watchdog bound, set above what the run would need even if every transaction
    // were a full-table query under the longest stalls.
    localparam int     CYCLE_LIMIT = 20000000;
    // Quiet time that covers a load still in flight after the last result.
    localparam int     SETTLE_CYCLES = 32;

    typedef logic signed [pits_pkg::COORD_WIDTH_DEF-1:0] t_coord;

    // One command transaction as it appears on the command channel.
    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] entry_index;
        t_coord           v0x;
        t_coord           v0z;
        t_coord           v1x;
        t_coord           v1z;
        t_coord           v2x;
        t_coord           v2z;
        t_coord           qx;
        t_coord           qz;
    } t_tri_cmd;

    // One search answer as it appears on the result channel.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] triangle_index;
    } t_search_result;

    logic clk;
    logic rst_n;

    pits_cmd_if cmd_bus ();
    pits_res_if res_bus ();
    pits_cfg_if cfg_bus ();

    point_in_triangle_table_search_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_bus.sink),
        .o_res   (res_bus.source),
        .i_cfg   (cfg_bus.sink)
    );

    // Commands waiting to be driven, and search answers still owed by the unit.
    t_tri_cmd       cmd_backlog [$];
    t_search_result awaited_searches [$];

    // Shadow of the unit: its triangle table and the scan count register.
    t_coord           tbl_v0x [TABLE_SLOTS];
    t_coord           tbl_v0z [TABLE_SLOTS];
    t_coord           tbl_v1x [TABLE_SLOTS];
    t_coord           tbl_v1z [TABLE_SLOTS];
    t_coord           tbl_v2x [TABLE_SLOTS];
    t_coord           tbl_v2z [TABLE_SLOTS];
    logic [CNT_W-1:0] scan_count_cfg = '0;

    // What the stimulus side has loaded so far, used to aim queries at triangles
    // and to keep every scan inside slots that were written.
    t_tri_cmd gen_tri    [TABLE_SLOTS];
    bit       gen_loaded [TABLE_SLOTS];

    bit cmd_taken     = 1'b0;
    int cmd_gap       = 0;
    int res_stall     = 0;
    bit idle_on       = 1'b0;
    bit calm_tail     = 1'b0;
    int cycle_count   = 0;
    int mismatch_count = 0;

    // Clock, and every input of the unit at a known value from time zero.
    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = pits_pkg::CMD_LOAD;
        cmd_bus.entry_index = '0;
        cmd_bus.vertex0_x = '0;
        cmd_bus.vertex0_z = '0;
        cmd_bus.vertex1_x = '0;
        cmd_bus.vertex1_z = '0;
        cmd_bus.vertex2_x = '0;
        cmd_bus.vertex2_z = '0;
        cmd_bus.query_x = '0;
        cmd_bus.query_z = '0;
        res_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data = '0;
        forever #2 clk = ~clk;
    end

    function automatic longint wide(t_coord v);
        return v;
    endfunction

    function automatic t_coord clip(longint v);
        if (v > COORD_MAX) begin
            return t_coord'(COORD_MAX);
        end
        if (v < COORD_MIN) begin
            return t_coord'(COORD_MIN);
        end
        return t_coord'(v);
    endfunction

    // Sign of a*b - c*d. The factors are at most 17 bits, so 64-bit math is exact.
    function automatic int cross_sign(longint a, longint b, longint c, longint d);
        longint diff;
        diff = a * b - c * d;
        if (diff > 0) begin
            return 1;
        end
        return (diff < 0) ? -1 : 0;
    endfunction

    // Strict containment by the signed-area test: every edge cross product must
    // carry the sign of the doubled area, taken as positive when the area is zero.
    // A zero-area triangle or a point on an edge therefore never matches.
    function automatic bit strictly_inside(int slot, t_coord px, t_coord pz);
        longint x0, z0, x1, z1, x2, z2;
        int     want;
        x0 = wide(tbl_v0x[slot]);
        z0 = wide(tbl_v0z[slot]);
        x1 = wide(tbl_v1x[slot]);
        z1 = wide(tbl_v1z[slot]);
        x2 = wide(tbl_v2x[slot]);
        z2 = wide(tbl_v2z[slot]);
        want = (cross_sign(x1 - x0, z2 - z0, z1 - z0, x2 - x0) < 0) ? -1 : 1;
        return cross_sign(z2 - z0, wide(px) - x0, x2 - x0, wide(pz) - z0) == want
            && cross_sign(x1 - x0, wide(pz) - z0, z1 - z0, wide(px) - x0) == want
            && cross_sign(x2 - x1, wide(pz) - z1, z2 - z1, wide(px) - x1) == want;
    endfunction

    // Scan the shadow table in slot order and return the first enclosing triangle.
    // A count above the table size scans the whole table and no more.
    function automatic t_search_result first_enclosing_triangle(t_coord px, t_coord pz);
        t_search_result hit;
        int             limit;
        hit = '0;
        limit = (scan_count_cfg > TABLE_SLOTS) ? TABLE_SLOTS : int'(scan_count_cfg);
        for (int k = 0; k < limit; k++) begin
            if (strictly_inside(k, px, pz)) begin
                hit.found = 1'b1;
                hit.triangle_index = IDX_W'(k);
                break;
            end
        end
        return hit;
    endfunction

    // Command driver. A new transaction is presented at the falling edge right after
    // the previous one was taken, or after a short random gap between transactions.
    always @(negedge clk) begin
        logic     present;
        t_tri_cmd next_cmd;
        if (cmd_taken) begin
            cmd_taken = 1'b0;
            present = 1'b0;
        end else begin
            present = cmd_bus.valid;
        end
        if (rst_n && !present) begin
            if (cmd_gap > 0) begin
                cmd_gap--;
            end else if (cmd_backlog.size() > 0) begin
                if (idle_on && !calm_tail && $urandom_range(0, 4) == 0) begin
                    cmd_gap = $urandom_range(0, 3);
                end else begin
                    next_cmd = cmd_backlog.pop_front();
                    cmd_bus.command <= next_cmd.command;
                    cmd_bus.entry_index <= next_cmd.entry_index;
                    cmd_bus.vertex0_x <= next_cmd.v0x;
                    cmd_bus.vertex0_z <= next_cmd.v0z;
                    cmd_bus.vertex1_x <= next_cmd.v1x;
                    cmd_bus.vertex1_z <= next_cmd.v1z;
                    cmd_bus.vertex2_x <= next_cmd.v2x;
                    cmd_bus.vertex2_z <= next_cmd.v2z;
                    cmd_bus.query_x <= next_cmd.qx;
                    cmd_bus.query_z <= next_cmd.qz;
                    present = 1'b1;
                end
            end
        end
        cmd_bus.valid <= present;
    end

    // Result receiver. It stalls in random bursts, so that a finished
    // query sometimes has to wait behind an unread answer.
    always @(negedge clk) begin
        if (res_stall > 0) begin
            res_stall--;
            res_bus.ready <= 1'b0;
        end else if (idle_on && !calm_tail && $urandom_range(0, 4) == 0) begin
            res_stall = $urandom_range(0, 3);
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // Monitor. At each rising edge it follows register writes and accepted commands
    // in the shadow model and checks every answer against the oldest prediction.
    always @(posedge clk) begin
        t_search_result want;
        t_search_result got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no progress within %0d cycles", $realtime, CYCLE_LIMIT);
            $display("point_in_triangle_table_search_unit_test NOT OK");
            $finish;
        end else if (rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                scan_count_cfg = cfg_bus.data;
            end
            if (cmd_bus.valid && cmd_bus.ready) begin
                cmd_taken = 1'b1;
                if (cmd_bus.command == pits_pkg::CMD_LOAD) begin
                    tbl_v0x[cmd_bus.entry_index] = cmd_bus.vertex0_x;
                    tbl_v0z[cmd_bus.entry_index] = cmd_bus.vertex0_z;
                    tbl_v1x[cmd_bus.entry_index] = cmd_bus.vertex1_x;
                    tbl_v1z[cmd_bus.entry_index] = cmd_bus.vertex1_z;
                    tbl_v2x[cmd_bus.entry_index] = cmd_bus.vertex2_x;
                    tbl_v2z[cmd_bus.entry_index] = cmd_bus.vertex2_z;
                end else begin
                    awaited_searches.push_back(
                        first_enclosing_triangle(cmd_bus.query_x, cmd_bus.query_z));
                end
            end
            if (res_bus.valid && res_bus.ready) begin
                got.found = res_bus.found;
                got.triangle_index = res_bus.triangle_index;
                if (awaited_searches.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual found=%0d index=%0d",
                             $realtime, got.found, got.triangle_index);
                end else begin
                    want = awaited_searches.pop_front();
                    if (got.found !== want.found) begin
                        mismatch_count++;
                        $display("%0t: found mismatch, expected %0d, actual %0d",
                                 $realtime, want.found, got.found);
                    end
                    if (got.triangle_index !== want.triangle_index) begin
                        mismatch_count++;
                        $display("%0t: triangle_index mismatch, expected %0d, actual %0d",
                                 $realtime, want.triangle_index, got.triangle_index);
                    end
                end
            end
        end
    end

    task automatic queue_load(int slot, t_coord x0, t_coord z0, t_coord x1, t_coord z1,
                              t_coord x2, t_coord z2);
        t_tri_cmd item;
        item.command = pits_pkg::CMD_LOAD;
        item.entry_index = IDX_W'(slot);
        item.v0x = x0;
        item.v0z = z0;
        item.v1x = x1;
        item.v1z = z1;
        item.v2x = x2;
        item.v2z = z2;
        item.qx = t_coord'($urandom);
        item.qz = t_coord'($urandom);
        cmd_backlog.push_back(item);
        gen_tri[slot] = item;
        gen_loaded[slot] = 1'b1;
    endtask

    task automatic queue_query(t_coord x, t_coord z);
        t_tri_cmd item;
        item.command = pits_pkg::CMD_QUERY;
        item.entry_index = IDX_W'($urandom);
        item.v0x = t_coord'($urandom);
        item.v0z = t_coord'($urandom);
        item.v1x = t_coord'($urandom);
        item.v1z = t_coord'($urandom);
        item.v2x = t_coord'($urandom);
        item.v2z = t_coord'($urandom);
        item.qx = x;
        item.qz = z;
        cmd_backlog.push_back(item);
    endtask

    // Triangles of many sizes all over the plane, a crowd around the origin so
    // that they overlap, full-range ones, and some with zero area.
    task automatic queue_random_load(int slot);
        t_coord p [6];
        longint cx, cz, spread;
        int     style;
        style = $urandom_range(0, 19);
        cx = longint'($urandom_range(0, 60000)) - 30000;
        cz = longint'($urandom_range(0, 60000)) - 30000;
        spread = longint'(1) << $urandom_range(2, 12);
        if (style >= 12 && style < 15) begin
            cx = 0;
            cz = 0;
            spread = 2048;
        end
        for (int k = 0; k < 6; k++) begin
            p[k] = clip(((k % 2 == 0) ? cx : cz)
                        + longint'($urandom_range(0, int'(2 * spread))) - spread);
            if (style >= 15 && style < 18) begin
                p[k] = t_coord'($urandom);
            end
        end
        if (style == 18) begin
            p[4] = p[0];
            p[5] = p[1];
        end else if (style == 19) begin
            p[2] = p[4];
            p[3] = p[5];
        end
        queue_load(slot, p[0], p[1], p[2], p[3], p[4], p[5]);
    endtask

    // Most queries aim at a loaded triangle in the scanned range: inside it, on a
    // corner, on an edge, or just around it. The rest land anywhere.
    task automatic queue_random_query(int live);
        t_tri_cmd t;
        longint   a, b, c;
        int       style;
        style = $urandom_range(0, 19);
        if (live > 0) begin
            t = gen_tri[$urandom_range(0, live - 1)];
        end
        a = $urandom_range(1, 16);
        b = $urandom_range(1, 16);
        c = $urandom_range(1, 16);
        if (live == 0 || style >= 17) begin
            queue_query(t_coord'($urandom), t_coord'($urandom));
        end else if (style < 10) begin
            queue_query(clip((a * wide(t.v0x) + b * wide(t.v1x) + c * wide(t.v2x)) / (a + b + c)),
                        clip((a * wide(t.v0z) + b * wide(t.v1z) + c * wide(t.v2z)) / (a + b + c)));
        end else if (style < 12) begin
            case ($urandom_range(0, 2))
                0: queue_query(t.v0x, t.v0z);
                1: queue_query(t.v1x, t.v1z);
                default: queue_query(t.v2x, t.v2z);
            endcase
        end else if (style < 14) begin
            if (style == 12) begin
                queue_query(clip((wide(t.v0x) + wide(t.v1x)) >>> 1),
                            clip((wide(t.v0z) + wide(t.v1z)) >>> 1));
            end else begin
                queue_query(clip((wide(t.v1x) + wide(t.v2x)) >>> 1),
                            clip((wide(t.v1z) + wide(t.v2z)) >>> 1));
            end
        end else begin
            queue_query(clip(wide(t.v2x) + longint'($urandom_range(0, 1024)) - 512),
                        clip(wide(t.v2z) + longint'($urandom_range(0, 1024)) - 512));
        end
    endtask

    // Writes the scan count through the register channel; only called while idle.
    task automatic write_scan_count(int value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data <= CNT_W'(value);
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Waits until every command is taken and every answer is in, then lets a load
    // that may still be in flight finish.
    task automatic drain();
        while (cmd_backlog.size() != 0 || cmd_bus.valid || awaited_searches.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One phase: a register setting, loads that cover every slot the scan will
    // read, then a random mix of queries and loads.
    task automatic run_random_phase(int count, int n_items, bit calm);
        int live;
        drain();
        write_scan_count(count);
        calm_tail = calm;
        idle_on = ($urandom_range(0, 3) != 0);
        live = (count > TABLE_SLOTS) ? TABLE_SLOTS : count;
        for (int k = 0; k < live; k++) begin
            if (!gen_loaded[k]) begin
                queue_random_load(k);
            end
        end
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 9) < 6) begin
                queue_random_query(live);
            end else if (live > 0 && $urandom_range(0, 9) < 7) begin
                queue_random_load($urandom_range(0, live - 1));
            end else begin
                queue_random_load($urandom_range(0, TABLE_SLOTS - 1));
            end
        end
    endtask

    function automatic int random_scan_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 0;
        end
        return (pick < 8) ? $urandom_range(2, 16) : $urandom_range(17, 40);
    endfunction

    // Stimulus sequence.
    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed part. With a count of zero nothing is scanned.
        write_scan_count(0);
        queue_query(0, 0);
        // A small counterclockwise triangle, two full-range triangles of opposite
        // winding that share the anti-diagonal x + z = -1 as an edge, and a
        // zero-area triangle in front of the second full-range one.
        queue_load(0, 0, 0, 1024, 0, 0, 1024);
        queue_load(1, -32768, -32768, -32768, 32767, 32767, -32768);
        queue_load(2, 5000, 5000, 5000, 5000, 6000, 7000);
        queue_load(3, 32767, 32767, -32768, 32767, 32767, -32768);
        drain();
        write_scan_count(4);
        queue_query(100, 100);       // inside slots 0 and 3: the lower slot wins
        queue_query(0, 0);           // corner of slot 0
        queue_query(512, 0);         // edge of slot 0
        queue_query(-1000, -1000);   // inside the clockwise slot 1
        queue_query(5500, 6000);     // skips the zero-area slot 2, lands in slot 3
        queue_query(32767, -32768);  // corner shared by slots 1 and 3
        queue_query(-32768, -32768); // extreme corner of slot 1
        queue_query(-1, 0);          // on the shared anti-diagonal edge
        drain();
        write_scan_count(1);
        queue_query(-1000, -1000);   // slot 1 now lies past the scanned range
        queue_query(100, 100);

        run_random_phase(1, 100, 1'b0);
        for (int k = 0; k < 4; k++) begin
            run_random_phase(random_scan_count(), 100, 1'b0);
        end

        // Full table: slots 0 to 254 sit far from slot 255, so a point inside the
        // last slot is found only after a scan of the whole table.
        drain();
        write_scan_count(TABLE_SLOTS);
        idle_on = 1'b1;
        for (int k = 0; k < TABLE_SLOTS - 1; k++) begin
            queue_load(k, t_coord'(-20000 + int'($urandom_range(0, 2048))),
                       t_coord'(-20000 + int'($urandom_range(0, 2048))),
                       t_coord'(-20000 + int'($urandom_range(0, 2048))),
                       t_coord'(-20000 + int'($urandom_range(0, 2048))),
                       t_coord'(-20000 + int'($urandom_range(0, 2048))),
                       t_coord'(-20000 + int'($urandom_range(0, 2048))));
        end
        queue_load(TABLE_SLOTS - 1, 20000, 20000, 21000, 20000, 20000, 21000);
        queue_query(20200, 20200);
        queue_query(0, 0);
        queue_random_query(TABLE_SLOTS);
        // Counts above the table size scan the table once and stop.
        drain();
        write_scan_count((1 << CNT_W) - 1);
        queue_query(20200, 20200);
        queue_query(0, 0);
        drain();
        write_scan_count(TABLE_SLOTS + 44);
        queue_query(20200, 20200);

        for (int k = 0; k < 4; k++) begin
            run_random_phase(random_scan_count(), 100, 1'b0);
        end
        // Last phase runs at full rate on both sides.
        run_random_phase($urandom_range(4, 16), 120, 1'b1);

        drain();
        if (mismatch_count == 0) begin
            $display("point_in_triangle_table_search_unit_test OK");
        end else begin
            $display("point_in_triangle_table_search_unit_test NOT OK");
        end
        $finish;
    end

endmodule
